FILE: src/ptg_pkg.sv
// Shared types, constants and saturating helpers of the polynomial trajectory generator.
package ptg_pkg;

    localparam int DATA_BITS_DEF = 32;
    localparam int FRAC_BITS_DEF = 16;
    localparam int S_BITS        = 30;
    localparam int MAG_BITS      = 62;

    // Configuration register indexes.
    localparam logic [2:0] REG_START_POS  = 3'd0;
    localparam logic [2:0] REG_END_POS    = 3'd1;
    localparam logic [2:0] REG_START_VEL  = 3'd2;
    localparam logic [2:0] REG_END_VEL    = 3'd3;
    localparam logic [2:0] REG_BEGIN_TIME = 3'd4;
    localparam logic [2:0] REG_FINISH_TIME = 3'd5;
    localparam logic [2:0] REG_QUINTIC    = 3'd6;

    // Phase codes.
    localparam logic [1:0] PH_BEFORE = 2'd0;
    localparam logic [1:0] PH_WITHIN = 2'd1;
    localparam logic [1:0] PH_AFTER  = 2'd2;

    typedef logic signed [63:0] t_wide;

    localparam t_wide LIM = 64'sh3FFF_FFFF_FFFF_FFFF;

    typedef struct packed {
        t_wide [5:0] cp;
        t_wide [4:0] cv;
        t_wide [3:0] ca;
    } t_coef;

    // Sum of two values in range, clamped to the internal limit.
    function automatic t_wide sat_add(t_wide a, t_wide b);
        logic signed [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s > $signed({1'b0, LIM})) begin
            return LIM;
        end else if (s < -$signed({1'b0, LIM})) begin
            return -LIM;
        end
        return s[63:0];
    endfunction

    // Product with a small positive constant, clamped to the internal limit.
    function automatic t_wide mul_const(t_wide a, logic [4:0] k);
        logic [63:0] mag;
        logic [68:0] p;
        t_wide m;
        mag = a[63] ? 64'(-a) : 64'(a);
        p = {5'b0, mag} * {64'b0, k};
        m = (p > {5'b0, LIM}) ? LIM : t_wide'(p[63:0]);
        return a[63] ? -m : m;
    endfunction

endpackage

FILE: src/ptg_div.sv
// Pipelined restoring divider, one quotient bit per stage, with a sideband payload.
module ptg_div #(
    parameter int MB = 62,
    parameter int K  = 16,
    parameter int QB = 62,
    parameter int DB = 32,
    parameter int SW = 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  logic [MB-1:0] i_num,
    input  logic          i_neg,
    input  logic [DB-1:0] i_den,
    input  logic [SW-1:0] i_side,
    output logic          o_valid,
    output logic [QB-1:0] o_quot,
    output logic          o_ovf,
    output logic          o_neg,
    output logic [SW-1:0] o_side
);

    localparam int NB = MB + K;
    localparam int HB = NB - QB;
    localparam int CW = ((HB > DB) ? HB : DB) + 1;

    logic          r_valid [QB+1];
    logic [DB:0]   r_rem   [QB+1];
    logic [QB-1:0] r_bits  [QB+1];
    logic [QB-1:0] r_q     [QB+1];
    logic          r_ovf   [QB+1];
    logic          r_neg   [QB+1];
    logic [SW-1:0] r_side  [QB+1];

    logic [NB-1:0] w_full;
    logic [HB-1:0] w_head;
    logic          w_ovf;

    // Leading part of the shifted dividend; a quotient too wide is flagged here.
    assign w_full = {i_num, {K{1'b0}}};
    assign w_head = w_full[NB-1:QB];
    assign w_ovf  = CW'(w_head) >= CW'(i_den);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid[0] <= 1'b0;
        end else if (i_en) begin
            r_valid[0] <= i_valid;
        end
        if (i_en) begin
            r_rem[0]  <= w_ovf ? '0 : (DB+1)'(w_head);
            r_bits[0] <= w_full[QB-1:0];
            r_q[0]    <= '0;
            r_ovf[0]  <= w_ovf;
            r_neg[0]  <= i_neg;
            r_side[0] <= i_side;
        end
    end

    // One shift, compare and subtract per stage.
    for (genvar k = 1; k <= QB; k++) begin : g_step
        logic [DB:0] w_trial;
        logic        w_ge;
        assign w_trial = {r_rem[k-1][DB-1:0], r_bits[k-1][QB-1]};
        assign w_ge    = w_trial >= {1'b0, i_den};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[k] <= 1'b0;
            end else if (i_en) begin
                r_valid[k] <= r_valid[k-1];
            end
            if (i_en) begin
                r_rem[k]  <= w_ge ? w_trial - {1'b0, i_den} : w_trial;
                r_bits[k] <= r_bits[k-1] << 1;
                r_q[k]    <= {r_q[k-1][QB-2:0], w_ge};
                r_ovf[k]  <= r_ovf[k-1];
                r_neg[k]  <= r_neg[k-1];
                r_side[k] <= r_side[k-1];
            end
        end
    end

    assign o_valid = r_valid[QB];
    assign o_quot  = r_q[QB];
    assign o_ovf   = r_ovf[QB];
    assign o_neg   = r_neg[QB];
    assign o_side  = r_side[QB];

endmodule

FILE: src/ptg_hstep.sv
// One Horner step on three lanes: multiply by s, rescale, add the next coefficient.
module ptg_hstep #(
    parameter int SW = 3
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  logic                    i_valid,
    input  ptg_pkg::t_wide [2:0]    i_acc,
    input  ptg_pkg::t_wide [2:0]    i_coef,
    input  logic [ptg_pkg::S_BITS:0] i_s,
    input  logic [SW-1:0]           i_side,
    output logic                    o_valid,
    output ptg_pkg::t_wide [2:0]    o_acc,
    output logic [ptg_pkg::S_BITS:0] o_s,
    output logic [SW-1:0]           o_side
);

    localparam int SB = ptg_pkg::S_BITS + 1;
    localparam int HW = ptg_pkg::MAG_BITS / 2;

    logic [2:0]            r1_valid;
    logic [2:0]            r1_neg;
    logic [2:0][2*HW-1:0]  r1_phi;
    logic [2:0][2*HW-1:0]  r1_plo;
    logic [SB-1:0]         r1_s, r2_s, r3_s;
    logic [SW-1:0]         r1_side, r2_side, r3_side;
    ptg_pkg::t_wide [2:0]  r2_q;
    ptg_pkg::t_wide [2:0]  r3_acc;

    // Stage 1: magnitude split into halves, two narrow products per lane.
    always_ff @(posedge i_clk) begin
        logic [63:0] mag;
        if (!i_rst_n) begin
            r1_valid <= '0;
        end else if (i_en) begin
            r1_valid <= {r1_valid[1:0], i_valid};
        end
        if (i_en) begin
            for (int l = 0; l < 3; l++) begin
                mag = i_acc[l][63] ? 64'(-i_acc[l]) : 64'(i_acc[l]);
                r1_neg[l] <= i_acc[l][63];
                r1_phi[l] <= (2*HW)'(mag[2*HW-1:HW]) * (2*HW)'(i_s);
                r1_plo[l] <= (2*HW)'(mag[HW-1:0]) * (2*HW)'(i_s);
            end
            r1_s    <= i_s;
            r1_side <= i_side;
        end
    end

    // Stage 2: partial products joined and scaled back by 2^-30.
    always_ff @(posedge i_clk) begin
        logic [3*HW:0] full;
        ptg_pkg::t_wide q;
        if (i_en) begin
            for (int l = 0; l < 3; l++) begin
                full = {r1_phi[l], {HW{1'b0}}} + (3*HW+1)'(r1_plo[l]);
                q = ptg_pkg::t_wide'(full[2*HW+ptg_pkg::S_BITS-1:ptg_pkg::S_BITS]);
                r2_q[l] <= r1_neg[l] ? -q : q;
            end
            r2_s    <= r1_s;
            r2_side <= r1_side;
        end
    end

    // Stage 3: saturating add of this step's coefficient.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int l = 0; l < 3; l++) begin
                r3_acc[l] <= ptg_pkg::sat_add(r2_q[l], i_coef[l]);
            end
            r3_s    <= r2_s;
            r3_side <= r2_side;
        end
    end

    assign o_valid = r1_valid[2];
    assign o_acc   = r3_acc;
    assign o_s     = r3_s;
    assign o_side  = r3_side;

endmodule

FILE: src/ptg_coef.sv
// Polynomial coefficients and derivative coefficients formed from the segment registers.
module ptg_coef #(
    parameter int DB = 32,
    parameter int F  = 16
) (
    input  logic                 i_clk,
    input  logic signed [DB-1:0] i_p0,
    input  logic signed [DB-1:0] i_pf,
    input  logic signed [DB-1:0] i_v0,
    input  logic signed [DB-1:0] i_vf,
    input  logic [DB-1:0]        i_t0,
    input  logic [DB-1:0]        i_t1,
    input  logic                 i_quintic,
    output logic [DB-1:0]        o_dur,
    output ptg_pkg::t_coef       o_coef
);

    localparam int H  = (DB + 1) / 2;
    localparam int PW = 2 * DB;

    logic [DB-1:0]        r_dur;
    logic [1:0]           r1_neg;
    logic [1:0][PW-1:0]   r1_hh, r1_hl, r1_lh, r1_ll;
    ptg_pkg::t_wide       r1_p0, r1_dx;
    ptg_pkg::t_wide       r2_a, r2_b, r2_p0, r2_dx;
    ptg_pkg::t_wide       r3_a, r3_p0, r3_y1, r3_y2, r3_cub2, r3_cub3;
    logic                 r3_quin;
    ptg_pkg::t_wide [5:0] r4_c;
    ptg_pkg::t_coef       r5_coef;

    logic [DB-1:0] w_dur;
    assign w_dur = i_t1 - i_t0;

    // Stage 1: velocity times duration as four half-width products.
    always_ff @(posedge i_clk) begin
        logic [DB-1:0] mag;
        logic [DB-1:0] vel [2];
        vel[0] = i_v0;
        vel[1] = i_vf;
        r_dur <= w_dur;
        for (int k = 0; k < 2; k++) begin
            mag = vel[k][DB-1] ? DB'(-$signed(vel[k])) : vel[k];
            r1_neg[k] <= vel[k][DB-1];
            r1_hh[k] <= PW'(mag[DB-1:H]) * PW'(w_dur[DB-1:H]);
            r1_hl[k] <= PW'(mag[DB-1:H]) * PW'(w_dur[H-1:0]);
            r1_lh[k] <= PW'(mag[H-1:0]) * PW'(w_dur[DB-1:H]);
            r1_ll[k] <= PW'(mag[H-1:0]) * PW'(w_dur[H-1:0]);
        end
        r1_p0 <= ptg_pkg::t_wide'(i_p0);
        r1_dx <= ptg_pkg::t_wide'(i_pf) - ptg_pkg::t_wide'(i_p0);
    end

    // Stage 2: products joined, scaled by 2^-F and clamped.
    always_ff @(posedge i_clk) begin
        logic [PW+1:0] full;
        logic [PW+1:0] q;
        ptg_pkg::t_wide m [2];
        for (int k = 0; k < 2; k++) begin
            full = ((PW+2)'(r1_hh[k]) << (2*H)) + ((PW+2)'(r1_hl[k]) << H)
                 + ((PW+2)'(r1_lh[k]) << H) + (PW+2)'(r1_ll[k]);
            q = full >> F;
            m[k] = (q > (PW+2)'(ptg_pkg::LIM)) ? ptg_pkg::LIM : ptg_pkg::t_wide'(q);
            if (r1_neg[k]) begin
                m[k] = -m[k];
            end
        end
        r2_a  <= m[0];
        r2_b  <= m[1];
        r2_p0 <= r1_p0;
        r2_dx <= r1_dx;
    end

    // Stage 3: shared differences and the cubic terms.
    always_ff @(posedge i_clk) begin
        r3_a    <= r2_a;
        r3_p0   <= r2_p0;
        r3_quin <= i_quintic;
        r3_y1   <= ptg_pkg::sat_add(r2_dx, -r2_a);
        r3_y2   <= ptg_pkg::sat_add(r2_b, -r2_a);
        r3_cub2 <= ptg_pkg::sat_add(ptg_pkg::sat_add(ptg_pkg::mul_const(r2_dx, 5'd3),
                   -ptg_pkg::mul_const(r2_a, 5'd2)), -r2_b);
        r3_cub3 <= ptg_pkg::sat_add(ptg_pkg::sat_add(-ptg_pkg::mul_const(r2_dx, 5'd2),
                   r2_a), r2_b);
    end

    // Stage 4: coefficient set for the selected mode.
    always_ff @(posedge i_clk) begin
        r4_c[0] <= r3_p0;
        r4_c[1] <= r3_a;
        if (r3_quin) begin
            r4_c[2] <= '0;
            r4_c[3] <= ptg_pkg::sat_add(ptg_pkg::mul_const(r3_y1, 5'd10),
                       -ptg_pkg::mul_const(r3_y2, 5'd4));
            r4_c[4] <= ptg_pkg::sat_add(ptg_pkg::mul_const(r3_y2, 5'd7),
                       -ptg_pkg::mul_const(r3_y1, 5'd15));
            r4_c[5] <= ptg_pkg::sat_add(ptg_pkg::mul_const(r3_y1, 5'd6),
                       -ptg_pkg::mul_const(r3_y2, 5'd3));
        end else begin
            r4_c[2] <= r3_cub2;
            r4_c[3] <= r3_cub3;
            r4_c[4] <= '0;
            r4_c[5] <= '0;
        end
    end

    // Stage 5: first and second derivative coefficients.
    always_ff @(posedge i_clk) begin
        r5_coef.cp <= r4_c;
        for (int i = 0; i < 5; i++) begin
            r5_coef.cv[i] <= ptg_pkg::mul_const(r4_c[i+1], 5'(i + 1));
        end
        for (int i = 0; i < 4; i++) begin
            r5_coef.ca[i] <= ptg_pkg::mul_const(r4_c[i+2], 5'((i + 2) * (i + 1)));
        end
    end

    assign o_dur  = r_dur;
    assign o_coef = r5_coef;

endmodule

FILE: src/polynomial_trajectory_generator.sv
// Top level of the one-axis cubic or quintic polynomial trajectory generator.
// The block accepts one sample time per clock while its output is not stalled and
// returns position, velocity, acceleration, phase and a timing flag for each, in
// order. Most of the pipeline is made of the three bit-serial division chains
// (the normalized time and two divisions by the duration) and the five Horner
// steps of three stages each. A stalled output holds the whole pipeline. Segment
// registers are written through the configuration channel, which is always ready;
// derived coefficients are registered in the coefficient stages and settle well
// before an item that follows the write reaches them. An end time not after the
// start time holds the start position and raises the timing flag.
module polynomial_trajectory_generator #(
    parameter int DATA_BITS = ptg_pkg::DATA_BITS_DEF,
    parameter int FRAC_BITS = ptg_pkg::FRAC_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [DATA_BITS-1:0]        i_sample_time,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic signed [DATA_BITS-1:0] o_position_out,
    output logic signed [DATA_BITS-1:0] o_velocity_out,
    output logic signed [DATA_BITS-1:0] o_accel_out,
    output logic [1:0]                  o_phase,
    output logic                        o_bad_timing,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [2:0]                  i_cfg_index,
    input  logic [DATA_BITS-1:0]        i_cfg_data
);

    localparam int DB = DATA_BITS;
    localparam int SB = ptg_pkg::S_BITS + 1;
    localparam int MB = ptg_pkg::MAG_BITS;
    localparam int AW = 3 + 64 + 64;

    logic signed [DB-1:0] r_p0, r_pf, r_v0, r_vf;
    logic [DB-1:0]        r_t0, r_t1;
    logic                 r_quintic;

    logic                 w_en;
    logic [DB-1:0]        w_dur;
    ptg_pkg::t_coef       w_coef;

    // Configuration transactions.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p0 <= '0;
            r_pf <= '0;
            r_v0 <= '0;
            r_vf <= '0;
            r_t0 <= '0;
            r_t1 <= DB'(1) << FRAC_BITS;
            r_quintic <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                ptg_pkg::REG_START_POS:   r_p0 <= i_cfg_data;
                ptg_pkg::REG_END_POS:     r_pf <= i_cfg_data;
                ptg_pkg::REG_START_VEL:   r_v0 <= i_cfg_data;
                ptg_pkg::REG_END_VEL:     r_vf <= i_cfg_data;
                ptg_pkg::REG_BEGIN_TIME:  r_t0 <= i_cfg_data;
                ptg_pkg::REG_FINISH_TIME: r_t1 <= i_cfg_data;
                ptg_pkg::REG_QUINTIC:     r_quintic <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    ptg_coef #(.DB(DB), .F(FRAC_BITS)) u_coef (
        .i_clk(i_clk), .i_p0(r_p0), .i_pf(r_pf), .i_v0(r_v0), .i_vf(r_vf),
        .i_t0(r_t0), .i_t1(r_t1), .i_quintic(r_quintic),
        .o_dur(w_dur), .o_coef(w_coef)
    );

    // The whole pipeline advances together unless a finished result waits.
    logic r_out_valid;
    assign o_in_stall = r_out_valid && i_out_stall;
    assign w_en       = !o_in_stall;

    // Entry stage: clamp the sample into the segment and find the phase.
    logic          r0_valid;
    logic [DB-1:0] r0_tau;
    logic [1:0]    r0_ph;
    logic          r0_bad;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_valid <= 1'b0;
        end else if (w_en) begin
            r0_valid <= i_in_valid;
        end
        if (w_en) begin
            r0_bad <= r_t1 <= r_t0;
            if (i_sample_time < r_t0) begin
                r0_tau <= '0;
                r0_ph  <= ptg_pkg::PH_BEFORE;
            end else if (i_sample_time < r_t1) begin
                r0_tau <= i_sample_time - r_t0;
                r0_ph  <= ptg_pkg::PH_WITHIN;
            end else begin
                r0_tau <= r_t1 - r_t0;
                r0_ph  <= ptg_pkg::PH_AFTER;
            end
        end
    end

    // Normalized time s = tau * 2^30 / T.
    logic          w_s_valid, w_s_ovf, w_s_neg;
    logic [SB-1:0] w_s;
    logic [2:0]    w_s_side;

    ptg_div #(.MB(DB), .K(ptg_pkg::S_BITS), .QB(SB), .DB(DB), .SW(3)) u_sdiv (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en), .i_valid(r0_valid),
        .i_num(r0_tau), .i_neg(1'b0), .i_den(w_dur), .i_side({r0_bad, r0_ph}),
        .o_valid(w_s_valid), .o_quot(w_s), .o_ovf(w_s_ovf), .o_neg(w_s_neg),
        .o_side(w_s_side)
    );

    // Horner chain: lane 0 position, lane 1 first and lane 2 second derivative.
    logic                 h_valid [6];
    ptg_pkg::t_wide [2:0] h_acc   [6];
    logic [SB-1:0]        h_s     [6];
    logic [2:0]           h_side  [6];

    assign h_valid[0] = w_s_valid;
    assign h_acc[0]   = {64'sd0, 64'sd0, w_coef.cp[5]};
    assign h_s[0]     = (w_s_ovf || w_s_neg) ? '0 : w_s;
    assign h_side[0]  = w_s_side;

    for (genvar j = 0; j < 5; j++) begin : g_horner
        ptg_pkg::t_wide [2:0] w_c;
        if (j == 0) begin : g_first
            assign w_c = {64'sd0, w_coef.cv[4], w_coef.cp[4]};
        end else begin : g_rest
            assign w_c = {w_coef.ca[4-j], w_coef.cv[4-j], w_coef.cp[4-j]};
        end
        ptg_hstep #(.SW(3)) u_step (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en), .i_valid(h_valid[j]),
            .i_acc(h_acc[j]), .i_coef(w_c), .i_s(h_s[j]), .i_side(h_side[j]),
            .o_valid(h_valid[j+1]), .o_acc(h_acc[j+1]), .o_s(h_s[j+1]),
            .o_side(h_side[j+1])
        );
    end

    // Magnitudes of the derivative sums for the divisions by T.
    ptg_pkg::t_wide w_pos, w_dp, w_ddp;
    logic [63:0]    w_dp_mag, w_ddp_mag;
    assign w_pos     = h_acc[5][0];
    assign w_dp      = h_acc[5][1];
    assign w_ddp     = h_acc[5][2];
    assign w_dp_mag  = w_dp[63] ? 64'(-w_dp) : 64'(w_dp);
    assign w_ddp_mag = w_ddp[63] ? 64'(-w_ddp) : 64'(w_ddp);

    logic          w_v_valid, w_v_ovf, w_v_neg;
    logic [MB-1:0] w_v_q;
    logic [2:0]    w_v_side;
    logic          w_a1_valid, w_a1_ovf, w_a1_neg;
    logic [MB-1:0] w_a1_q;
    logic [63:0]   w_a1_side;

    ptg_div #(.MB(MB), .K(FRAC_BITS), .QB(MB), .DB(DB), .SW(3)) u_vdiv (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en), .i_valid(h_valid[5]),
        .i_num(w_dp_mag[MB-1:0]), .i_neg(w_dp[63]), .i_den(w_dur), .i_side(h_side[5]),
        .o_valid(w_v_valid), .o_quot(w_v_q), .o_ovf(w_v_ovf), .o_neg(w_v_neg),
        .o_side(w_v_side)
    );

    ptg_div #(.MB(MB), .K(FRAC_BITS), .QB(MB), .DB(DB), .SW(64)) u_a1div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en), .i_valid(h_valid[5]),
        .i_num(w_ddp_mag[MB-1:0]), .i_neg(w_ddp[63]), .i_den(w_dur), .i_side(w_pos),
        .o_valid(w_a1_valid), .o_quot(w_a1_q), .o_ovf(w_a1_ovf), .o_neg(w_a1_neg),
        .o_side(w_a1_side)
    );

    // Signed, clamped velocity; clamped magnitude of the first acceleration quotient.
    ptg_pkg::t_wide w_vel;
    logic [MB-1:0]  w_a1_mag;
    always_comb begin
        ptg_pkg::t_wide m;
        m = w_v_ovf ? ptg_pkg::LIM : ptg_pkg::t_wide'({2'b0, w_v_q});
        w_vel = w_v_neg ? -m : m;
    end
    assign w_a1_mag = w_a1_ovf ? ptg_pkg::LIM[MB-1:0] : w_a1_q;

    logic          w_a2_valid, w_a2_ovf, w_a2_neg;
    logic [MB-1:0] w_a2_q;
    logic [AW-1:0] w_a2_side;

    ptg_div #(.MB(MB), .K(FRAC_BITS), .QB(MB), .DB(DB), .SW(AW)) u_a2div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en),
        .i_valid(w_v_valid && w_a1_valid), .i_num(w_a1_mag), .i_neg(w_a1_neg),
        .i_den(w_dur), .i_side({w_v_side, w_a1_side, w_vel}),
        .o_valid(w_a2_valid), .o_quot(w_a2_q), .o_ovf(w_a2_ovf), .o_neg(w_a2_neg),
        .o_side(w_a2_side)
    );

    // Clamp to the output width.
    function automatic logic signed [DB-1:0] out_sat(ptg_pkg::t_wide v);
        ptg_pkg::t_wide hi;
        ptg_pkg::t_wide lo;
        hi = ptg_pkg::t_wide'((65'sd1 <<< (DB - 1)) - 65'sd1);
        lo = -hi - 64'sd1;
        if (v > hi) begin
            return hi[DB-1:0];
        end else if (v < lo) begin
            return lo[DB-1:0];
        end
        return v[DB-1:0];
    endfunction

    // Output register.
    always_ff @(posedge i_clk) begin
        ptg_pkg::t_wide m;
        ptg_pkg::t_wide acc;
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= w_a2_valid;
        end
        if (w_en) begin
            m   = w_a2_ovf ? ptg_pkg::LIM : ptg_pkg::t_wide'({2'b0, w_a2_q});
            acc = w_a2_neg ? -m : m;
            o_phase      <= w_a2_side[AW-2:AW-3];
            o_bad_timing <= w_a2_side[AW-1];
            if (w_a2_side[AW-1]) begin
                o_position_out <= r_p0;
                o_velocity_out <= '0;
                o_accel_out    <= '0;
            end else begin
                o_position_out <= out_sat(w_a2_side[127:64]);
                o_velocity_out <= out_sat(w_a2_side[63:0]);
                o_accel_out    <= out_sat(acc);
            end
        end
    end

    assign o_out_valid = r_out_valid;

    // The input side is held only while a finished result is refused.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall))
        else $error("input stalled without a waiting result");

    a_bad_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_bad_timing) |-> (o_velocity_out == '0 && o_accel_out == '0))
        else $error("bad timing result carries motion");

    a_bad_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_bad_timing) |-> (o_phase != ptg_pkg::PH_WITHIN))
        else $error("bad timing result reports within phase");

    a_held_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_position_out)))
        else $error("stalled result changed");

endmodule

FILE: sim/polynomial_trajectory_generator_test.sv
// Self-checking testbench for the one-axis polynomial trajectory generator.
`timescale 1ns / 100ps

module polynomial_trajectory_generator_test;

    localparam int DW = 32;
    localparam int FW = 16;
    localparam int LATENCY = 200;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int RANDOM_ITEMS = 1400;
    localparam logic signed [63:0] WLIM = 64'sh3FFF_FFFF_FFFF_FFFF;

    typedef struct packed {
        logic signed [DW-1:0] position;
        logic signed [DW-1:0] velocity;
        logic signed [DW-1:0] accel;
        logic [1:0]           phase;
        logic                 bad;
    } t_setpoint;

    typedef struct {
        logic [DW-1:0] t;
        logic          typed;
        t_setpoint     sp;
    } t_stim_row;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [DW-1:0] sample_time = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic signed [DW-1:0] position_out, velocity_out, accel_out;
    logic [1:0] phase_out;
    logic bad_timing_out;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [2:0] cfg_index = '0;
    logic [DW-1:0] cfg_data = '0;

    // Shadow copy of the segment registers.
    logic signed [63:0] seg_p0, seg_pf, seg_v0, seg_vf;
    logic [63:0] seg_t0, seg_t1;
    logic seg_quintic;

    t_setpoint expected_q[$];
    int errors = 0;
    int checked = 0;
    int bad_seen = 0;
    int phase_seen[3] = '{0, 0, 0};
    int idle_cycles = 0;
    bit calm = 1'b0;

    always #5 clk = ~clk;

    polynomial_trajectory_generator DUT (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .o_in_stall(in_stall), .i_sample_time(sample_time),
        .o_out_valid(out_valid), .i_out_stall(out_stall),
        .o_position_out(position_out), .o_velocity_out(velocity_out),
        .o_accel_out(accel_out), .o_phase(phase_out), .o_bad_timing(bad_timing_out),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data)
    );

    function automatic logic signed [63:0] clamp_wide(logic signed [127:0] v);
        if (v > 128'sd0 + WLIM) return WLIM;
        if (v < -(128'sd0 + WLIM)) return -WLIM;
        return v[63:0];
    endfunction

    function automatic logic signed [63:0] wadd(logic signed [63:0] a, logic signed [63:0] b);
        return clamp_wide(128'(a) + 128'(b));
    endfunction

    // Truncating product scaled down by 2^k, magnitude based.
    function automatic logic signed [63:0] wmul(logic signed [63:0] a, logic signed [63:0] b,
                                                int k);
        logic [63:0] ma, mb;
        logic [127:0] p;
        logic [127:0] q;
        ma = a[63] ? 64'(-a) : 64'(a);
        mb = b[63] ? 64'(-b) : 64'(b);
        p = 128'(ma) * 128'(mb);
        q = p >> k;
        if (q > 128'(WLIM)) q = 128'(WLIM);
        return (a[63] != b[63]) ? -$signed(q[63:0]) : $signed(q[63:0]);
    endfunction

    // Truncating quotient of x*2^k by d; the quotient keeps 62 bits and saturates.
    function automatic logic signed [63:0] wdiv(logic signed [63:0] x, logic [63:0] d, int k);
        logic [63:0] m;
        logic [191:0] q;
        m = x[63] ? 64'(-x) : 64'(x);
        if (d == 0) return 0;
        q = (192'(m) << k) / 192'(d);
        if (q > 192'(WLIM)) q = 192'(WLIM);
        return x[63] ? -$signed(q[63:0]) : $signed(q[63:0]);
    endfunction

    function automatic logic signed [DW-1:0] narrow(logic signed [63:0] v);
        if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
        if (v < -64'sd2147483648) return 32'sh8000_0000;
        return v[DW-1:0];
    endfunction

    // Set point for one sample time under the shadow segment.
    function automatic t_setpoint trajectory_point(logic [DW-1:0] t_in);
        t_setpoint r;
        logic [63:0] t, dur, tau;
        logic signed [63:0] c[6], d1[5], d2[4];
        logic signed [63:0] s, dx, a, b, y1, y2, pos, dp, ddp;
        t = 64'(t_in);
        r = '0;
        if (seg_t1 <= seg_t0) begin
            r.position = narrow(seg_p0);
            r.phase = (t < seg_t0) ? ptg_pkg::PH_BEFORE : ptg_pkg::PH_AFTER;
            r.bad = 1'b1;
            return r;
        end
        dur = seg_t1 - seg_t0;
        if (t < seg_t0) begin
            tau = 0; r.phase = ptg_pkg::PH_BEFORE;
        end else if (t < seg_t1) begin
            tau = t - seg_t0; r.phase = ptg_pkg::PH_WITHIN;
        end else begin
            tau = dur; r.phase = ptg_pkg::PH_AFTER;
        end
        s = wdiv($signed(tau), dur, ptg_pkg::S_BITS);
        dx = seg_pf - seg_p0;
        a = wmul(seg_v0, $signed(dur), FW);
        b = wmul(seg_vf, $signed(dur), FW);
        c[0] = seg_p0;
        c[1] = a;
        if (seg_quintic) begin
            y1 = wadd(dx, -a);
            y2 = wadd(b, -a);
            c[2] = 0;
            c[3] = wadd(wmul(y1, 10, 0), -wmul(y2, 4, 0));
            c[4] = wadd(wmul(y2, 7, 0), -wmul(y1, 15, 0));
            c[5] = wadd(wmul(y1, 6, 0), -wmul(y2, 3, 0));
        end else begin
            c[2] = wadd(wadd(wmul(dx, 3, 0), -wmul(a, 2, 0)), -b);
            c[3] = wadd(wadd(-wmul(dx, 2, 0), a), b);
            c[4] = 0;
            c[5] = 0;
        end
        for (int i = 1; i <= 5; i++) d1[i-1] = wmul(c[i], i, 0);
        for (int i = 2; i <= 5; i++) d2[i-2] = wmul(c[i], i * (i - 1), 0);
        // Horner evaluation of the polynomial and its two derivatives.
        pos = c[5];
        for (int i = 4; i >= 0; i--) pos = wadd(wmul(pos, s, ptg_pkg::S_BITS), c[i]);
        dp = d1[4];
        for (int i = 3; i >= 0; i--) dp = wadd(wmul(dp, s, ptg_pkg::S_BITS), d1[i]);
        ddp = d2[3];
        for (int i = 2; i >= 0; i--) ddp = wadd(wmul(ddp, s, ptg_pkg::S_BITS), d2[i]);
        r.position = narrow(pos);
        r.velocity = narrow(wdiv(dp, dur, FW));
        r.accel = narrow(wdiv(wdiv(ddp, dur, FW), dur, FW));
        return r;
    endfunction

    // Register write through the configuration channel, mirrored in the shadow.
    // The valid stays high; the caller drops it after the last write.
    task automatic write_segment_reg(logic [2:0] idx, logic [DW-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            ptg_pkg::REG_START_POS:   seg_p0 = 64'($signed(val));
            ptg_pkg::REG_END_POS:     seg_pf = 64'($signed(val));
            ptg_pkg::REG_START_VEL:   seg_v0 = 64'($signed(val));
            ptg_pkg::REG_END_VEL:     seg_vf = 64'($signed(val));
            ptg_pkg::REG_BEGIN_TIME:  seg_t0 = 64'(val);
            ptg_pkg::REG_FINISH_TIME: seg_t1 = 64'(val);
            ptg_pkg::REG_QUINTIC:     seg_quintic = val[0];
            default: ;
        endcase
    endtask

    task automatic load_segment(logic [DW-1:0] p0, logic [DW-1:0] pf, logic [DW-1:0] v0,
                                logic [DW-1:0] vf, logic [DW-1:0] t0, logic [DW-1:0] t1,
                                logic q);
        write_segment_reg(ptg_pkg::REG_START_POS, p0);
        write_segment_reg(ptg_pkg::REG_END_POS, pf);
        write_segment_reg(ptg_pkg::REG_START_VEL, v0);
        write_segment_reg(ptg_pkg::REG_END_VEL, vf);
        write_segment_reg(ptg_pkg::REG_BEGIN_TIME, t0);
        write_segment_reg(ptg_pkg::REG_FINISH_TIME, t1);
        write_segment_reg(ptg_pkg::REG_QUINTIC, {31'b0, q});
        cfg_valid <= 1'b0;
    endtask

    // Sends one sample; a typed expectation replaces the predicted one when given.
    // The valid stays high for a following sample; a gap or drain drops it.
    task automatic send_sample(logic [DW-1:0] t, logic typed, t_setpoint sp);
        int gap;
        if (!calm && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 5);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        sample_time <= t;
        do @(posedge clk); while (in_stall);
        if (typed && trajectory_point(t) != sp)
            $error("typed expectation disagrees with predictor at t=%h", t);
        expected_q.push_back(typed ? sp : trajectory_point(t));
    endtask

    task automatic drain;
        in_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge clk);
        repeat (LATENCY) @(posedge clk);
    endtask

    // Output stall bursts.
    initial begin
        int burst;
        forever begin
            @(posedge clk);
            if (!calm && $urandom_range(0, 6) == 0) begin
                burst = $urandom_range(1, 5);
                out_stall <= 1'b1;
                repeat (burst) @(posedge clk);
            end
            out_stall <= 1'b0;
        end
    end

    // Output check against the oldest expectation.
    always @(posedge clk) begin
        t_setpoint e;
        if (rst_n && out_valid && !out_stall) begin
            if (expected_q.size() == 0) begin
                $error("result transaction with nothing expected");
                errors++;
            end else begin
                e = expected_q.pop_front();
                checked++;
                if (e.bad) bad_seen++;
                if (e.phase <= ptg_pkg::PH_AFTER) phase_seen[e.phase]++;
                if (position_out !== e.position) begin
                    $error("position_out expected %h actual %h", e.position, position_out);
                    errors++;
                end
                if (velocity_out !== e.velocity) begin
                    $error("velocity_out expected %h actual %h", e.velocity, velocity_out);
                    errors++;
                end
                if (accel_out !== e.accel) begin
                    $error("accel_out expected %h actual %h", e.accel, accel_out);
                    errors++;
                end
                if (phase_out !== e.phase) begin
                    $error("phase expected %0d actual %0d", e.phase, phase_out);
                    errors++;
                end
                if (bad_timing_out !== e.bad) begin
                    $error("bad_timing expected %0d actual %0d", e.bad, bad_timing_out);
                    errors++;
                end
            end
        end
    end

    // Watchdog on cycles without any transaction.
    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("polynomial_trajectory_generator_test: done, errors");
            $finish;
        end
    end

    function automatic logic [DW-1:0] rand_time_near(logic [DW-1:0] t0, logic [DW-1:0] t1);
        logic [DW-1:0] span;
        span = t1 - t0;
        case ($urandom_range(0, 7))
            0: return $urandom();
            1: return t0;
            2: return t1;
            3: return t0 - $urandom_range(1, 4);
            4: return t1 + $urandom_range(0, 4);
            default: return (t1 > t0) ? t0 + ($urandom() % (span == 0 ? 1 : span)) : $urandom();
        endcase
    endfunction

    initial begin
        t_stim_row rows[$];
        t_stim_row row;
        t_setpoint none;
        logic [DW-1:0] t0, t1, p0;
        int sent;
        none = '0;
        seg_p0 = 0; seg_pf = 0; seg_v0 = 0; seg_vf = 0;
        seg_t0 = 0; seg_t1 = 64'd1 << FW; seg_quintic = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed rows under reset settings: everything is at rest at zero.
        rows.push_back('{32'h0, 1'b1, '{0, 0, 0, ptg_pkg::PH_WITHIN, 1'b0}});
        rows.push_back('{32'h8000, 1'b1, '{0, 0, 0, ptg_pkg::PH_WITHIN, 1'b0}});
        rows.push_back('{32'h10000, 1'b1, '{0, 0, 0, ptg_pkg::PH_AFTER, 1'b0}});
        rows.push_back('{32'hFFFF_FFFF, 1'b1, '{0, 0, 0, ptg_pkg::PH_AFTER, 1'b0}});
        foreach (rows[i]) send_sample(rows[i].t, rows[i].typed, rows[i].sp);
        drain();

        // Cubic segment with motion at both ends.
        load_segment(32'h0001_0000, 32'h000A_0000, 32'h0002_0000, 32'hFFFF_0000,
                     32'h0001_0000, 32'h0003_0000, 1'b0);
        rows.delete();
        rows.push_back('{32'h0, 1'b0, none});
        rows.push_back('{32'h0001_0000, 1'b0, none});
        rows.push_back('{32'h0001_8000, 1'b0, none});
        rows.push_back('{32'h0002_FFFF, 1'b0, none});
        rows.push_back('{32'h0003_0000, 1'b0, none});
        rows.push_back('{32'hFFFF_FFFF, 1'b0, none});
        foreach (rows[i]) send_sample(rows[i].t, rows[i].typed, rows[i].sp);
        drain();

        // Quintic segment with extreme end positions and velocities.
        load_segment(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                     32'h0, 32'h0000_0001, 1'b1);
        send_sample(32'h0, 1'b0, none);
        send_sample(32'h1, 1'b0, none);
        send_sample(32'hFFFF_FFFF, 1'b0, none);
        drain();

        // Bad timing: end equal to or before start, position held, flag raised.
        load_segment(32'h1234_5678, 32'h0, 32'h0, 32'h0, 32'h0005_0000, 32'h0005_0000, 1'b0);
        send_sample(32'h0004_0000, 1'b1, '{32'h1234_5678, 0, 0, ptg_pkg::PH_BEFORE, 1'b1});
        send_sample(32'h0005_0000, 1'b1, '{32'h1234_5678, 0, 0, ptg_pkg::PH_AFTER, 1'b1});
        drain();
        write_segment_reg(ptg_pkg::REG_BEGIN_TIME, 32'hFFFF_FFFF);
        write_segment_reg(ptg_pkg::REG_FINISH_TIME, 32'h0);
        cfg_valid <= 1'b0;
        send_sample(32'h0, 1'b1, '{32'h1234_5678, 0, 0, ptg_pkg::PH_BEFORE, 1'b1});
        send_sample(32'hFFFF_FFFF, 1'b1, '{32'h1234_5678, 0, 0, ptg_pkg::PH_AFTER, 1'b1});
        drain();

        // Random segments, each followed by a burst of samples.
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            if (sent > RANDOM_ITEMS * 4 / 5) calm = 1'b1;
            case ($urandom_range(0, 9))
                0: begin t0 = $urandom(); t1 = $urandom(); end
                1: begin t0 = $urandom_range(0, 32'h0010_0000); t1 = t0; end
                2: begin t0 = 32'hFFFF_0000; t1 = 32'hFFFF_FFFF; end
                3: begin t0 = 32'h0; t1 = $urandom_range(1, 64); end
                default: begin
                    t0 = $urandom_range(0, 32'h0100_0000);
                    t1 = t0 + $urandom_range(1, 32'h0008_0000);
                end
            endcase
            p0 = ($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(0, 32'h00FF_FFFF)
                 - 32'h0080_0000;
            load_segment(p0,
                         ($urandom_range(0, 3) == 0) ? $urandom()
                             : p0 + $urandom_range(0, 32'h00FF_FFFF) - 32'h0080_0000,
                         ($urandom_range(0, 3) == 0) ? $urandom()
                             : $urandom_range(0, 32'h0007_FFFF) - 32'h0004_0000,
                         ($urandom_range(0, 3) == 0) ? $urandom()
                             : $urandom_range(0, 32'h0007_FFFF) - 32'h0004_0000,
                         t0, t1, $urandom_range(0, 1));
            repeat ($urandom_range(10, 40)) begin
                send_sample(rand_time_near(t0, t1), 1'b0, none);
                sent++;
            end
            drain();
        end

        calm = 1'b1;
        drain();
        $display("Checked %0d set points (%0d with bad timing), phases before/within/after %0d/%0d/%0d.",
                 checked, bad_seen, phase_seen[0], phase_seen[1], phase_seen[2]);
        if (errors == 0 && expected_q.size() == 0) begin
            $display("polynomial_trajectory_generator_test: done, clean");
        end else begin
            $display("polynomial_trajectory_generator_test: done, errors");
        end
        $finish;
    end

endmodule
